// ===== hw/rtl/tagged_integer_alu_assert.svh =====
// Assertion macros for the tagged integer ALU checker.
`ifndef TAGGED_INTEGER_ALU_ASSERT_SVH
`define TAGGED_INTEGER_ALU_ASSERT_SVH
// Property that must hold in the cycle after the antecedent.
`define TIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tagged_integer_alu check failed");
// Property that must hold in the same cycle.
`define TIA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tagged_integer_alu check failed");
`endif

// ===== hw/rtl/tia_pkg.sv =====
// Shared types, opcodes and constants of the tagged integer ALU.
`timescale 1ns / 1ps
package tia_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned ImmW = 32;
  localparam int unsigned OpW = 5;
  localparam int unsigned QBits = WordW / 2;
  localparam int unsigned CellCount = QBits;

  localparam logic [OpW-1:0] OP_NEG = 5'd0;
  localparam logic [OpW-1:0] OP_ADD = 5'd1;
  localparam logic [OpW-1:0] OP_SUB = 5'd2;
  localparam logic [OpW-1:0] OP_MUL = 5'd3;
  localparam logic [OpW-1:0] OP_DIV = 5'd4;
  localparam logic [OpW-1:0] OP_MOD = 5'd5;
  localparam logic [OpW-1:0] OP_AND = 5'd6;
  localparam logic [OpW-1:0] OP_OR = 5'd7;
  localparam logic [OpW-1:0] OP_XOR = 5'd8;
  localparam logic [OpW-1:0] OP_LSL = 5'd9;
  localparam logic [OpW-1:0] OP_LSR = 5'd10;
  localparam logic [OpW-1:0] OP_ASR = 5'd11;
  localparam logic [OpW-1:0] OP_EQ = 5'd12;
  localparam logic [OpW-1:0] OP_NE = 5'd13;
  localparam logic [OpW-1:0] OP_LT = 5'd14;
  localparam logic [OpW-1:0] OP_LE = 5'd15;
  localparam logic [OpW-1:0] OP_GT = 5'd16;
  localparam logic [OpW-1:0] OP_GE = 5'd17;
  localparam logic [OpW-1:0] OP_OFFSET = 5'd18;
  localparam logic [OpW-1:0] OP_NOT = 5'd19;
  localparam logic [OpW-1:0] OP_CONST = 5'd20;

  localparam logic [WordW-1:0] TagFalse = 64'd1;
  localparam logic [WordW-1:0] TagTrue = 64'd3;

  // Item carried down the cell chain.
  typedef struct packed {
    logic              vld;
    logic [OpW-1:0]    op;
    logic [WordW-1:0]  res;     // result for ops that need no divide or multiply
    logic              zdiv;
    logic              pops;
    logic              is_div;  // divide or modulo in flight
    logic              neg_q;
    logic              neg_r;
    logic [WordW-1:0]  rem;     // partial remainder
    logic [WordW-1:0]  quo;     // dividend shifting out, quotient in
    logic [WordW-1:0]  dvs;     // divisor magnitude
    logic [WordW-1:0]  pa;      // untagged multiply operands
    logic [WordW-1:0]  pb;
  } tia_item_t;
endpackage

// ===== hw/rtl/tagged_integer_alu.sv =====
// Top level of the tagged integer ALU: entry stage, divider cell chain, exit stage.
//   channel  signals                                       dir
//   in       in_valid/in_ready op left_value right_value   in
//            immediate
//   out      out_valid/out_ready result_value zero_divide  out
//            pops_operand
// One beat per cycle while the output is not stalled; the pipe is the entry stage,
// 32 divider cells of two quotient bits each, and two exit stages.
// The whole pipe advances together; a stalled output holds every stage.
// Reset clears only the valid bits of the stages.
`timescale 1ns / 1ps
module tagged_integer_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tia_pkg::OpW-1:0]       op,
  input  logic signed [tia_pkg::WordW-1:0] left_value,
  input  logic signed [tia_pkg::WordW-1:0] right_value,
  input  logic signed [tia_pkg::ImmW-1:0]  immediate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tia_pkg::WordW-1:0] result_value,
  output logic                          zero_divide,
  output logic                          pops_operand
);
  import tia_pkg::*;

  localparam int unsigned Cells = CellCount;

  logic en;
  tia_item_t chain [Cells+1];

  assign en = ~out_valid | out_ready;
  assign in_ready = en;

  tia_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_valid),
    .op(op), .a(left_value), .b(right_value), .k(immediate),
    .dout(chain[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    tia_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .din(chain[i]), .dout(chain[i+1])
    );
  end

  tia_back u_back (
    .clk(clk), .rst(rst), .en(en), .din(chain[Cells]),
    .out_vld(out_valid), .res(result_value),
    .zdiv(zero_divide), .pops(pops_operand)
  );
endmodule

// ===== hw/rtl/tia_cell.sv =====
// One cell of the chain: two restoring divide steps and a pipeline register.
`timescale 1ns / 1ps
module tia_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tia_pkg::tia_item_t din,
  output tia_pkg::tia_item_t dout
);
  import tia_pkg::*;

  tia_item_t nxt;
  logic [WordW:0] t0, t1;
  logic [WordW-1:0] r0, q0;

  always_comb begin
    nxt = din;
    t0 = {din.rem, din.quo[WordW-1]} - {1'b0, din.dvs};
    r0 = t0[WordW] ? {din.rem[WordW-2:0], din.quo[WordW-1]} : t0[WordW-1:0];
    q0 = {din.quo[WordW-2:0], ~t0[WordW]};
    t1 = {r0, q0[WordW-1]} - {1'b0, din.dvs};
    nxt.rem = t1[WordW] ? {r0[WordW-2:0], q0[WordW-1]} : t1[WordW-1:0];
    nxt.quo = {q0[WordW-2:0], ~t1[WordW]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.op <= nxt.op;
      dout.res <= nxt.res;
      dout.zdiv <= nxt.zdiv;
      dout.pops <= nxt.pops;
      dout.is_div <= nxt.is_div;
      dout.neg_q <= nxt.neg_q;
      dout.neg_r <= nxt.neg_r;
      dout.rem <= din.is_div ? nxt.rem : din.rem;
      dout.quo <= din.is_div ? nxt.quo : din.quo;
      dout.dvs <= nxt.dvs;
      dout.pa <= nxt.pa;
      dout.pb <= nxt.pb;
    end
  end
endmodule

// ===== hw/rtl/tia_front.sv =====
// Entry stage: decode, operations that need no divide or multiply, and divide/multiply setup.
`timescale 1ns / 1ps
module tia_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [tia_pkg::OpW-1:0]       op,
  input  logic [tia_pkg::WordW-1:0]     a,
  input  logic [tia_pkg::WordW-1:0]     b,
  input  logic [tia_pkg::ImmW-1:0]      k,
  output tia_pkg::tia_item_t            dout
);
  import tia_pkg::*;

  tia_item_t nxt;
  logic [WordW-1:0] ua, ub, ma, mb, k64, am1;
  logic [5:0] sh;
  logic lt, gt, eq;

  always_comb begin
    ua = {a[WordW-1], a[WordW-1:1]};
    ub = {b[WordW-1], b[WordW-1:1]};
    ma = ua[WordW-1] ? -ua : ua;
    mb = ub[WordW-1] ? -ub : ub;
    k64 = {{(WordW-ImmW){k[ImmW-1]}}, k};
    am1 = a - 64'd1;
    sh = ub[5:0];
    lt = $signed(a) < $signed(b);
    gt = $signed(b) < $signed(a);
    eq = a == b;
    nxt = '0;
    nxt.vld = in_vld;
    nxt.op = op;
    nxt.pops = (op >= OP_ADD) && (op <= OP_GE);
    nxt.res = a;
    nxt.rem = '0;
    nxt.quo = ma;
    nxt.dvs = mb;
    nxt.neg_q = ua[WordW-1] ^ ub[WordW-1];
    nxt.neg_r = ua[WordW-1];
    nxt.pa = ua;
    nxt.pb = ub;
    case (op)
      OP_NEG: nxt.res = 64'd2 - a;
      OP_ADD: nxt.res = a + b - 64'd1;
      OP_SUB: nxt.res = a - b + 64'd1;
      OP_DIV, OP_MOD: begin
        if (b == 64'd1) begin
          nxt.zdiv = 1'b1;
          nxt.res = '0;
        end else begin
          nxt.is_div = 1'b1;
        end
      end
      OP_AND: nxt.res = a & b;
      OP_OR: nxt.res = a | b;
      OP_XOR: nxt.res = (a ^ b) | 64'd1;
      OP_LSL: nxt.res = (am1 << sh) + 64'd1;
      OP_LSR: nxt.res = (am1 >> sh) | 64'd1;
      OP_ASR: nxt.res = 64'($signed(am1) >>> sh) | 64'd1;
      OP_EQ: nxt.res = eq ? TagTrue : TagFalse;
      OP_NE: nxt.res = eq ? TagFalse : TagTrue;
      OP_LT: nxt.res = lt ? TagTrue : TagFalse;
      OP_LE: nxt.res = gt ? TagFalse : TagTrue;
      OP_GT: nxt.res = gt ? TagTrue : TagFalse;
      OP_GE: nxt.res = lt ? TagFalse : TagTrue;
      OP_OFFSET: nxt.res = a + {k64[WordW-2:0], 1'b0};
      OP_NOT: nxt.res = 64'd4 - a;
      OP_CONST: nxt.res = {k64[WordW-2:0], 1'b1};
      default: nxt.res = a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= nxt.vld;
    end
    if (en) begin
      dout.op <= nxt.op;
      dout.res <= nxt.res;
      dout.zdiv <= nxt.zdiv;
      dout.pops <= nxt.pops;
      dout.is_div <= nxt.is_div;
      dout.neg_q <= nxt.neg_q;
      dout.neg_r <= nxt.neg_r;
      dout.rem <= nxt.rem;
      dout.quo <= nxt.quo;
      dout.dvs <= nxt.dvs;
      dout.pa <= nxt.pa;
      dout.pb <= nxt.pb;
    end
  end
endmodule

// ===== hw/rtl/tia_back.sv =====
// Exit stage: multiply in three 32x32 partial products, sign fixup, tagging.
`timescale 1ns / 1ps
module tia_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  tia_pkg::tia_item_t        din,
  output logic                      out_vld,
  output logic [tia_pkg::WordW-1:0] res,
  output logic                      zdiv,
  output logic                      pops
);
  import tia_pkg::*;

  localparam int unsigned HalfW = WordW / 2;

  // stage 1: partial products
  logic              v1, z1, p1, d1, nq1, nr1;
  logic [OpW-1:0]    op1;
  logic [WordW-1:0]  r1, q1, m1;
  logic [WordW-1:0]  ll;
  logic [HalfW-1:0]  lh, hl;
  logic [WordW-1:0]  prod, v, fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= din.vld;
      out_vld <= v1;
    end
    if (en) begin
      z1 <= din.zdiv;
      p1 <= din.pops;
      d1 <= din.is_div;
      nq1 <= din.neg_q;
      nr1 <= din.neg_r;
      op1 <= din.op;
      r1 <= din.res;
      q1 <= din.quo;
      m1 <= din.rem;
      ll <= din.pa[HalfW-1:0] * din.pb[HalfW-1:0];
      lh <= din.pa[HalfW-1:0] * din.pb[WordW-1:HalfW];
      hl <= din.pa[WordW-1:HalfW] * din.pb[HalfW-1:0];
      res <= fin;
      zdiv <= z1;
      pops <= p1;
    end
  end

  always_comb begin
    prod = ll + {lh + hl, {HalfW{1'b0}}};
    if (op1 == OP_DIV) begin
      v = nq1 ? -q1 : q1;
    end else begin
      v = nr1 ? -m1 : m1;
    end
    if (d1) begin
      fin = {v[WordW-2:0], 1'b1};
    end else if (op1 == OP_MUL) begin
      fin = {prod[WordW-2:0], 1'b1};
    end else begin
      fin = r1;
    end
  end
endmodule

// ===== hw/rtl/tia_checker.sv =====
// Port-level checker for the tagged integer ALU, bound to the top level.
`timescale 1ns / 1ps
`include "tagged_integer_alu_assert.svh"
module tia_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [tia_pkg::WordW-1:0] result_value,
  input logic                     zero_divide,
  input logic                     pops_operand
);
  import tia_pkg::*;

  `TIA_ASSERT_NOW(a_zdiv_pops, out_valid && zero_divide, pops_operand)
  `TIA_ASSERT_NOW(a_zdiv_zero, out_valid && zero_divide, result_value == '0)
  `TIA_ASSERT_NOW(a_ready_free, !out_valid, in_ready)
  `TIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value))
endmodule

bind tagged_integer_alu tia_checker u_tia_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .result_value(result_value),
  .zero_divide(zero_divide), .pops_operand(pops_operand)
);
